// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top level of the tokenizer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cond implies prop in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("assertion failed: same-cycle implication");

// Check that cond implies prop in the following cycle.
`define ASSERT_NEXT(label, clk, rst_n, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/tcl_pkg.sv =====
// Types and constants of the three-column line tokenizer.
`default_nettype none

package tcl_pkg;

  localparam int unsigned OffsetBitsDef = 16;

  localparam logic [7:0] ChNul       = 8'h00;
  localparam logic [7:0] ChTab       = 8'h09;
  localparam logic [7:0] ChNewline   = 8'h0A;
  localparam logic [7:0] ChSpace     = 8'h20;
  localparam logic [7:0] ChHash      = 8'h23;
  localparam logic [7:0] ChQuote     = 8'h27;
  localparam logic [7:0] ChComma     = 8'h2C;
  localparam logic [7:0] ChDot       = 8'h2E;
  localparam logic [7:0] ChSemicolon = 8'h3B;
  localparam logic [7:0] ChBackslash = 8'h5C;

  localparam logic [2:0] ColsMax = 3'd4;

  typedef enum logic [2:0] {
    MODE_BETWEEN = 3'd0,
    MODE_TOKEN   = 3'd1,
    MODE_LITERAL = 3'd2,
    MODE_ESCAPE  = 3'd3,
    MODE_IGNORE  = 3'd4
  } mode_e;

  typedef struct packed {
    mode_e      mode;
    logic [2:0] cols;
    logic       after_nl;
  } scan_state_t;

  typedef struct packed {
    logic [1:0] start;
    logic [2:0] count;
    logic       done;
    logic       valid;
    logic       tdone;
    logic       restart;
  } step_res_t;

  localparam scan_state_t ScanStateRst = '{mode: MODE_BETWEEN, cols: 3'd0, after_nl: 1'b0};

endpackage

`default_nettype wire

// ===== rtl/tcl_step.sv =====
// Per-byte scanner transition and result decode.
`default_nettype none

module tcl_step (
  input  logic [7:0]          byte_i,
  input  tcl_pkg::scan_state_t cur_i,
  output tcl_pkg::scan_state_t nxt_o,
  output tcl_pkg::step_res_t   res_o
);

  logic       is_nul;
  logic       is_eol;
  logic       is_gap;
  logic       is_comment;
  logic [2:0] cols_inc;
  logic       cols_ok;

  assign is_nul     = (byte_i == tcl_pkg::ChNul);
  assign is_eol     = (byte_i == tcl_pkg::ChComma) || (byte_i == tcl_pkg::ChNewline);
  assign is_gap     = (byte_i == tcl_pkg::ChTab) || (byte_i == tcl_pkg::ChDot) ||
                      (byte_i == tcl_pkg::ChSpace);
  assign is_comment = (byte_i == tcl_pkg::ChHash) || (byte_i == tcl_pkg::ChSemicolon);
  assign cols_inc   = (cur_i.cols < tcl_pkg::ColsMax) ? cur_i.cols + 3'd1 : cur_i.cols;
  assign cols_ok    = (cur_i.cols == 3'd0) || (cur_i.cols == 3'd3);

  // Next state
  always_comb begin
    nxt_o          = cur_i;
    nxt_o.after_nl = 1'b0;
    if (is_nul) begin
      nxt_o = tcl_pkg::ScanStateRst;
    end else begin
      unique case (cur_i.mode) inside
        tcl_pkg::MODE_IGNORE: begin
        end
        tcl_pkg::MODE_LITERAL: begin
          if (byte_i == tcl_pkg::ChBackslash) begin
            nxt_o.mode = tcl_pkg::MODE_ESCAPE;
          end else if (byte_i == tcl_pkg::ChQuote) begin
            nxt_o.mode = tcl_pkg::MODE_TOKEN;
          end
        end
        tcl_pkg::MODE_ESCAPE: begin
          nxt_o.mode = tcl_pkg::MODE_LITERAL;
        end
        tcl_pkg::MODE_BETWEEN, tcl_pkg::MODE_TOKEN: begin
          if (is_eol) begin
            nxt_o.mode     = tcl_pkg::MODE_BETWEEN;
            nxt_o.cols     = 3'd0;
            nxt_o.after_nl = (byte_i == tcl_pkg::ChNewline);
          end else if (is_gap) begin
            nxt_o.mode = tcl_pkg::MODE_BETWEEN;
          end else if (cur_i.mode == tcl_pkg::MODE_BETWEEN) begin
            if (is_comment) begin
              nxt_o.mode = tcl_pkg::MODE_IGNORE;
              nxt_o.cols = 3'd0;
            end else begin
              nxt_o.cols = cols_inc;
              nxt_o.mode = (byte_i == tcl_pkg::ChQuote) ? tcl_pkg::MODE_LITERAL
                                                        : tcl_pkg::MODE_TOKEN;
            end
          end
        end
        default: begin
          nxt_o = tcl_pkg::ScanStateRst;
        end
      endcase
    end
  end

  // Result fields
  always_comb begin
    res_o       = '0;
    res_o.count = cur_i.cols;
    if (is_nul) begin
      res_o.restart = 1'b1;
      if (cur_i.mode != tcl_pkg::MODE_IGNORE) begin
        res_o.done  = !cur_i.after_nl;
        res_o.valid = !cur_i.after_nl && cols_ok;
        res_o.tdone = 1'b1;
      end
    end else if ((cur_i.mode == tcl_pkg::MODE_BETWEEN) ||
                 (cur_i.mode == tcl_pkg::MODE_TOKEN)) begin
      if (is_eol) begin
        res_o.done  = 1'b1;
        res_o.valid = cols_ok;
      end else if (is_gap) begin
        res_o.done = 1'b0;
      end else if (cur_i.mode == tcl_pkg::MODE_BETWEEN) begin
        if (is_comment) begin
          res_o.done  = 1'b1;
          res_o.valid = cols_ok;
          res_o.tdone = 1'b1;
        end else begin
          // open a new column; columns past the third get no start mark
          res_o.count = cols_inc;
          res_o.start = (cols_inc <= 3'd3) ? cols_inc[1:0] : 2'd0;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/three_column_line_tokenizer.sv =====
// Top level of the three-column line tokenizer.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+----------------------------------------
//   in      | to block  | in_valid_i/in_stall_o   | text_byte_i
//   out     | from block| out_valid_o/out_stall_i | byte_offset_o, column_start_o,
//           |           |                         | column_count_o, line_done_o,
//           |           |                         | line_valid_o, text_done_o
//
// One byte per cycle sustained while the output does not stall; an accepted request passes
// the input register, then the result register, which holds its result until it is taken.
// Reset clears the scanner state, position and both valid flags.
// A stall on the output holds the result register; the input register then holds too and
// in_stall_o rises only once it is occupied.
`default_nettype none

module three_column_line_tokenizer #(
  parameter int unsigned OFFSET_BITS = tcl_pkg::OffsetBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  text_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] byte_offset_o,
  output logic [1:0]  column_start_o,
  output logic [2:0]  column_count_o,
  output logic        line_done_o,
  output logic        line_valid_o,
  output logic        text_done_o
);

  `include "assert_macros.svh"

  logic                   in_valid_q;
  logic [7:0]             in_byte_q;
  tcl_pkg::scan_state_t   state_q;
  tcl_pkg::scan_state_t   state_d;
  logic [OFFSET_BITS-1:0] pos_q;
  logic [OFFSET_BITS-1:0] pos_d;
  tcl_pkg::step_res_t     step_res;
  logic                   res_load;
  logic                   proc;
  logic                   out_valid_q;
  logic [15:0]            offset_q;
  tcl_pkg::step_res_t     res_q;

  assign res_load   = !out_valid_q || !out_stall_i;
  assign proc       = in_valid_q && res_load;
  assign in_stall_o = in_valid_q && !res_load;

  tcl_step u_step (
    .byte_i (in_byte_q),
    .cur_i  (state_q),
    .nxt_o  (state_d),
    .res_o  (step_res)
  );

  assign pos_d = step_res.restart ? '0 : pos_q + OFFSET_BITS'(1);

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_byte_q <= text_byte_i;
    end
  end

  // scanner state: advance once per processed byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tcl_pkg::ScanStateRst;
      pos_q   <= '0;
    end else if (proc) begin
      state_q <= state_d;
      pos_q   <= pos_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_load) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc) begin
      offset_q <= 16'(pos_q);
      res_q    <= step_res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign byte_offset_o  = offset_q;
  assign column_start_o = res_q.start;
  assign column_count_o = res_q.count;
  assign line_done_o    = res_q.done;
  assign line_valid_o   = res_q.valid;
  assign text_done_o    = res_q.tdone;

  `ASSERT_IMPLIES(a_valid_needs_done, clk_i, rst_ni, out_valid_o && line_valid_o, line_done_o)
  `ASSERT_IMPLIES(a_start_matches_count, clk_i, rst_ni,
                  out_valid_o && (column_start_o != 2'd0),
                  column_count_o == {1'b0, column_start_o})
  `ASSERT_IMPLIES(a_cols_saturate, clk_i, rst_ni, 1'b1, state_q.cols <= tcl_pkg::ColsMax)
  `ASSERT_NEXT(a_restart_clears_pos, clk_i, rst_ni, proc && step_res.restart,
               (pos_q == '0) && (state_q == tcl_pkg::ScanStateRst))

endmodule

`default_nettype wire

// ===== bench/tb_three_column_line_tokenizer.sv =====
// Testbench for the three-column line tokenizer: directed rows, random texts, scoreboard.
module tb_three_column_line_tokenizer;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [15:0] offset;
    logic [1:0]  start;
    logic [2:0]  count;
    logic        done;
    logic        valid;
    logic        tdone;
  } byte_marks_t;

  // one request: the byte, plus a hand-written expectation where fixed is set
  typedef struct packed {
    logic [7:0]  ch;
    logic        fixed;
    byte_marks_t marks;
  } feed_t;

  localparam int NumDirected = 25;
  localparam int NumItems = 1700;
  localparam int TailItems = 200;
  localparam int StallLimit = 2000;
  localparam int LongHold = 40;

  localparam feed_t DirectedRows [NumDirected] = '{
    '{8'hFF, 1'b1, '{16'd0, 2'd1, 3'd1, 1'b0, 1'b0, 1'b0}},
    '{tcl_pkg::ChTab, 1'b0, '0},
    '{tcl_pkg::ChQuote, 1'b0, '0},
    '{tcl_pkg::ChDot, 1'b0, '0},
    '{tcl_pkg::ChBackslash, 1'b0, '0},
    '{tcl_pkg::ChQuote, 1'b0, '0},
    '{tcl_pkg::ChQuote, 1'b0, '0},
    '{tcl_pkg::ChSpace, 1'b0, '0},
    '{8'h78, 1'b0, '0},
    '{tcl_pkg::ChSpace, 1'b0, '0},
    '{8'h79, 1'b0, '0},
    '{tcl_pkg::ChComma, 1'b1, '{16'd11, 2'd0, 3'd4, 1'b1, 1'b0, 1'b0}},
    '{8'h61, 1'b0, '0},
    '{tcl_pkg::ChNewline, 1'b1, '{16'd13, 2'd0, 3'd1, 1'b1, 1'b0, 1'b0}},
    '{tcl_pkg::ChNul, 1'b1, '{16'd14, 2'd0, 3'd0, 1'b0, 1'b0, 1'b1}},
    '{tcl_pkg::ChComma, 1'b1, '{16'd0, 2'd0, 3'd0, 1'b1, 1'b1, 1'b0}},
    '{tcl_pkg::ChNul, 1'b1, '{16'd1, 2'd0, 3'd0, 1'b1, 1'b1, 1'b1}},
    '{tcl_pkg::ChQuote, 1'b0, '0},
    '{tcl_pkg::ChBackslash, 1'b0, '0},
    '{tcl_pkg::ChNul, 1'b1, '{16'd2, 2'd0, 3'd1, 1'b1, 1'b0, 1'b1}},
    '{tcl_pkg::ChHash, 1'b1, '{16'd0, 2'd0, 3'd0, 1'b1, 1'b1, 1'b1}},
    '{8'h41, 1'b1, '{16'd1, 2'd0, 3'd0, 1'b0, 1'b0, 1'b0}},
    '{tcl_pkg::ChNul, 1'b1, '{16'd2, 2'd0, 3'd0, 1'b0, 1'b0, 1'b0}},
    '{tcl_pkg::ChSemicolon, 1'b1, '{16'd0, 2'd0, 3'd0, 1'b1, 1'b1, 1'b1}},
    '{tcl_pkg::ChNul, 1'b1, '{16'd1, 2'd0, 3'd0, 1'b0, 1'b0, 1'b0}}
  };

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  text_byte_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [15:0] byte_offset_o;
  logic [1:0]  column_start_o;
  logic [2:0]  column_count_o;
  logic        line_done_o;
  logic        line_valid_o;
  logic        text_done_o;

  logic        fixed_now;
  byte_marks_t fixed_marks;

  feed_t       text_q[$];
  byte_marks_t marks_due[$];
  byte_marks_t seen;
  byte_marks_t want;
  byte_marks_t predicted;

  tcl_pkg::mode_e scan_mode_r = tcl_pkg::MODE_BETWEEN;
  logic [2:0]     cols_r = 3'd0;
  logic           after_nl_r = 1'b0;
  logic [15:0]    offset_r = 16'd0;

  int fail_count = 0;
  int results_seen = 0;
  int idle_cycles = 0;
  int cyc = 0;
  bit calm_tail = 1'b0;
  bit long_hold_done = 1'b0;

  three_column_line_tokenizer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .text_byte_i   (text_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .byte_offset_o (byte_offset_o),
    .column_start_o(column_start_o),
    .column_count_o(column_count_o),
    .line_done_o   (line_done_o),
    .line_valid_o  (line_valid_o),
    .text_done_o   (text_done_o)
  );

  initial clk_i = 1'b0;
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Advance the scanner by one byte and return the marks it reports.
  function automatic byte_marks_t tokenize_byte(input logic [7:0] ch);
    byte_marks_t m;
    logic finish;
    logic nl_before;
    m = '0;
    m.offset = offset_r;
    finish = 1'b0;
    nl_before = after_nl_r;
    after_nl_r = 1'b0;
    if (scan_mode_r == tcl_pkg::MODE_IGNORE) begin
      finish = (ch == tcl_pkg::ChNul);
    end else if (ch == tcl_pkg::ChNul) begin
      m.done = !nl_before;
      m.tdone = 1'b1;
      finish = 1'b1;
    end else if (scan_mode_r == tcl_pkg::MODE_LITERAL) begin
      if (ch == tcl_pkg::ChBackslash) begin
        scan_mode_r = tcl_pkg::MODE_ESCAPE;
      end else if (ch == tcl_pkg::ChQuote) begin
        scan_mode_r = tcl_pkg::MODE_TOKEN;
      end
    end else if (scan_mode_r == tcl_pkg::MODE_ESCAPE) begin
      scan_mode_r = tcl_pkg::MODE_LITERAL;
    end else if (ch == tcl_pkg::ChComma || ch == tcl_pkg::ChNewline) begin
      m.done = 1'b1;
      after_nl_r = (ch == tcl_pkg::ChNewline);
      scan_mode_r = tcl_pkg::MODE_BETWEEN;
    end else if (ch == tcl_pkg::ChTab || ch == tcl_pkg::ChDot || ch == tcl_pkg::ChSpace) begin
      scan_mode_r = tcl_pkg::MODE_BETWEEN;
    end else if (scan_mode_r == tcl_pkg::MODE_BETWEEN) begin
      if (ch == tcl_pkg::ChHash || ch == tcl_pkg::ChSemicolon) begin
        m.done = 1'b1;
        m.tdone = 1'b1;
        scan_mode_r = tcl_pkg::MODE_IGNORE;
      end else begin
        if (cols_r < tcl_pkg::ColsMax) begin
          cols_r = cols_r + 3'd1;
        end
        m.start = (cols_r < tcl_pkg::ColsMax) ? cols_r[1:0] : 2'd0;
        scan_mode_r = (ch == tcl_pkg::ChQuote) ? tcl_pkg::MODE_LITERAL : tcl_pkg::MODE_TOKEN;
      end
    end
    m.count = cols_r;
    m.valid = m.done && (cols_r == 3'd0 || cols_r == 3'd3);
    if (m.done) begin
      cols_r = 3'd0;
    end
    if (finish) begin
      scan_mode_r = tcl_pkg::MODE_BETWEEN;
      cols_r = 3'd0;
      after_nl_r = 1'b0;
      offset_r = 16'd0;
    end else begin
      offset_r = offset_r + 16'd1;
    end
    return m;
  endfunction

  function automatic bit is_marker(input logic [7:0] c);
    return c inside {tcl_pkg::ChNul, tcl_pkg::ChTab, tcl_pkg::ChNewline, tcl_pkg::ChSpace,
                     tcl_pkg::ChHash, tcl_pkg::ChQuote, tcl_pkg::ChComma, tcl_pkg::ChDot,
                     tcl_pkg::ChSemicolon, tcl_pkg::ChBackslash};
  endfunction

  function automatic logic [7:0] plain_byte();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(1, 255));
    end while (is_marker(c));
    return c;
  endfunction

  function automatic logic [7:0] gap_byte();
    case ($urandom_range(0, 2))
      0: return tcl_pkg::ChTab;
      1: return tcl_pkg::ChDot;
      default: return tcl_pkg::ChSpace;
    endcase
  endfunction

  function automatic logic [7:0] any_byte();
    return 8'($urandom_range(1, 255));
  endfunction

  task automatic put(input logic [7:0] c);
    text_q.push_back('{c, 1'b0, '0});
  endtask

  // Literal with separators and escapes inside; now and then left open.
  task automatic gen_literal();
    put(tcl_pkg::ChQuote);
    repeat ($urandom_range(0, 5)) begin
      case ($urandom_range(0, 5))
        0: put(gap_byte());
        1: put($urandom_range(0, 1) ? tcl_pkg::ChComma : tcl_pkg::ChNewline);
        2: begin
          put(tcl_pkg::ChBackslash);
          put(any_byte());
        end
        3: put($urandom_range(0, 1) ? tcl_pkg::ChHash : tcl_pkg::ChSemicolon);
        default: put(plain_byte());
      endcase
    end
    if ($urandom_range(0, 11) != 0) begin
      put(tcl_pkg::ChQuote);
      repeat ($urandom_range(0, 1)) put(plain_byte());
    end
  endtask

  task automatic gen_line(input bit closes);
    int ncols;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: ncols = 3;
      6, 7: ncols = 0;
      default: ncols = $urandom_range(1, 6);
    endcase
    for (int c = 0; c < ncols; c++) begin
      repeat ($urandom_range((c == 0) ? 0 : 1, 2)) put(gap_byte());
      if ($urandom_range(0, 3) == 0) begin
        gen_literal();
      end else begin
        repeat ($urandom_range(1, 4)) put(plain_byte());
      end
    end
    repeat ($urandom_range(0, 1)) put(gap_byte());
    if (closes) begin
      put($urandom_range(0, 1) ? tcl_pkg::ChComma : tcl_pkg::ChNewline);
    end
  endtask

  task automatic gen_text();
    if ($urandom_range(0, 6) == 0) begin
      repeat ($urandom_range(1, 12)) put(any_byte());
    end else begin
      repeat ($urandom_range(1, 4)) gen_line(1'b1);
      if ($urandom_range(0, 1) == 0) begin
        gen_line(1'b0);
      end
      if ($urandom_range(0, 7) == 0) begin
        put($urandom_range(0, 1) ? tcl_pkg::ChHash : tcl_pkg::ChSemicolon);
        repeat ($urandom_range(0, 5)) put(any_byte());
      end
    end
    put(tcl_pkg::ChNul);
  endtask

  // Monitor: predict on each accepted request, check each accepted result.
  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        seen = '{byte_offset_o, column_start_o, column_count_o, line_done_o,
                 line_valid_o, text_done_o};
        if (marks_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("unexpected result: offset %0d", byte_offset_o);
          end
        end else begin
          want = marks_due.pop_front();
          if (seen !== want) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("mismatch (exp/got): offset %0d/%0d start %0d/%0d count %0d/%0d",
                       want.offset, seen.offset, want.start, seen.start,
                       want.count, seen.count);
              $display("  line_done %0b/%0b line_valid %0b/%0b text_done %0b/%0b",
                       want.done, seen.done, want.valid, seen.valid,
                       want.tdone, seen.tdone);
            end
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        predicted = tokenize_byte(text_byte_i);
        marks_due.push_back(fixed_now ? fixed_marks : predicted);
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= StallLimit) begin
        $display("[three_column_line_tokenizer] ERROR");
        $finish;
      end
    end
  end

  // Result side: random stall bursts, one long hold-off, calm at the end.
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (!long_hold_done && results_seen >= 400) begin
        long_hold_done = 1'b1;
        out_stall_i <= 1'b1;
        repeat (LongHold) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if (!calm_tail && ((cyc / 113) % 4 != 1) && $urandom_range(0, 4) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // Request side: reset, build the texts, then feed them.
  initial begin
    int total;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    text_byte_i = tcl_pkg::ChNul;
    fixed_now = 1'b0;
    fixed_marks = '0;

    foreach (DirectedRows[i]) text_q.push_back(DirectedRows[i]);
    while (text_q.size() < NumItems) gen_text();
    total = text_q.size();

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int idx = 0; idx < total; idx++) begin
      if (idx == NumDirected) begin
        // drain the directed part before the random traffic starts
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        while (marks_due.size() != 0) @(posedge clk_i);
      end else if (idx >= total - TailItems) begin
        calm_tail = 1'b1;
      end else if (((idx / 97) % 4 != 3) && $urandom_range(0, 5) == 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
      end
      in_valid_i <= 1'b1;
      text_byte_i <= text_q[idx].ch;
      fixed_now <= text_q[idx].fixed;
      fixed_marks <= text_q[idx].marks;
      @(posedge clk_i);
      while (in_stall_o) @(posedge clk_i);
    end
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (marks_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("[three_column_line_tokenizer] OK");
    end else begin
      $display("[three_column_line_tokenizer] ERROR");
    end
    $finish;
  end

endmodule
